// ===== sv/hrf_pkg.sv =====
// ----------------------------------------------------------------------------
// hrf_pkg
// Shared types and constants of the HTTP request framer.
// ----------------------------------------------------------------------------
package hrf_pkg;

   typedef enum logic [1:0] {
      MODE_REQ  = 2'd0,
      MODE_HDR  = 2'd1,
      MODE_BODY = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      PH_PLAIN  = 2'd0,
      PH_CR     = 2'd1,
      PH_CRLF   = 2'd2,
      PH_CRLFCR = 2'd3
   } phase_type;

   localparam logic [1:0] SEC_REQ  = 2'd0;
   localparam logic [1:0] SEC_HDR  = 2'd1;
   localparam logic [1:0] SEC_BODY = 2'd2;

   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_SP    = 8'd32;
   localparam logic [7:0] CHAR_HT    = 8'd9;
   localparam logic [7:0] CHAR_COLON = 8'd58;
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;
   localparam logic [7:0] CHAR_UC_A  = 8'd65;
   localparam logic [7:0] CHAR_UC_Z  = 8'd90;
   localparam logic [7:0] CASE_OFS   = 8'd32;

   localparam logic [3:0] NAME_LEN = 4'd14;

   // lowercase "content-length"
   function automatic logic [7:0] name_char(input logic [3:0] pos);
      logic [7:0] c;
      case (pos)
         4'd0:    c = 8'h63;
         4'd1:    c = 8'h6f;
         4'd2:    c = 8'h6e;
         4'd3:    c = 8'h74;
         4'd4:    c = 8'h65;
         4'd5:    c = 8'h6e;
         4'd6:    c = 8'h74;
         4'd7:    c = 8'h2d;
         4'd8:    c = 8'h6c;
         4'd9:    c = 8'h65;
         4'd10:   c = 8'h6e;
         4'd11:   c = 8'h67;
         4'd12:   c = 8'h74;
         4'd13:   c = 8'h68;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // the tags of one result transaction, without the echo byte and the length field
   typedef struct packed {
      logic [1:0] section;
      logic       line_start;
      logic       header_done;
      logic       body_last;
   } tag_type;

endpackage

// ===== sv/hrf_in_stage.sv =====
// ----------------------------------------------------------------------------
// hrf_in_stage
// Input register of the request byte stream.
// ----------------------------------------------------------------------------
module hrf_in_stage
   import hrf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_byte,
   input  logic       advance,
   output logic       stage_valid,
   output logic [7:0] stage_byte
);

   logic       valid_ff;
   logic [7:0] byte_ff;

   assign req_tready  = !valid_ff || advance;
   assign stage_valid = valid_ff;
   assign stage_byte  = byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_tready) begin
         valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         byte_ff <= req_byte;
      end
   end

endmodule

// ===== sv/hrf_parser.sv =====
// ----------------------------------------------------------------------------
// hrf_parser
// Section tracking, header field matching and content length accumulation.
// ----------------------------------------------------------------------------
module hrf_parser
   import hrf_pkg::*;
#(
   parameter int LENGTH_BITS = 32
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             data_byte,
   output tag_type                tag,
   output logic [LENGTH_BITS-1:0] body_length
);

   typedef struct packed {
      logic [3:0]             name_pos;
      logic                   mismatch;
      logic                   in_value;
      logic                   skipping;
      logic                   digits_ended;
      logic [LENGTH_BITS-1:0] accum;
   } field_type;

   localparam field_type FIELD_CLEAR = '0;

   function automatic field_type field_byte(input field_type f, input logic [7:0] b);
      field_type              r;
      logic [7:0]             lc;
      logic [LENGTH_BITS+3:0] t;
      r  = f;
      lc = (b >= CHAR_UC_A && b <= CHAR_UC_Z) ? b + CASE_OFS : b;
      t  = ({4'b0, f.accum} << 3) + ({4'b0, f.accum} << 1)
         + (LENGTH_BITS+4)'(b - CHAR_ZERO);
      if (!f.in_value) begin
         if (b == CHAR_COLON) begin
            r.in_value     = 1'b1;
            r.skipping     = 1'b1;
            r.digits_ended = 1'b0;
            r.accum        = '0;
         end else if (!f.mismatch && f.name_pos < NAME_LEN &&
                      lc == name_char(f.name_pos)) begin
            r.name_pos = f.name_pos + 4'd1;
         end else begin
            r.mismatch = 1'b1;
         end
      end else if (!(f.skipping && (b == CHAR_SP || b == CHAR_HT))) begin
         r.skipping = 1'b0;
         if (!f.digits_ended && b >= CHAR_ZERO && b <= CHAR_NINE) begin
            r.accum = (t[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) ? '1 : t[LENGTH_BITS-1:0];
         end else begin
            r.digits_ended = 1'b1;
         end
      end
      return r;
   endfunction

   mode_type               mode_ff, mode_in;
   phase_type              phase_ff, phase_in;
   field_type              field_ff, field_in;
   logic [LENGTH_BITS-1:0] length_ff, length_in;
   logic [LENGTH_BITS-1:0] remain_ff, remain_in;

   logic                   is_ws;
   logic                   remain_le1;
   field_type              cleared_mis;

   assign is_ws      = (data_byte == CHAR_SP) || (data_byte == CHAR_HT);
   assign remain_le1 = (remain_ff[LENGTH_BITS-1:1] == '0);

   always_comb begin
      cleared_mis          = FIELD_CLEAR;
      cleared_mis.mismatch = 1'b1;
   end

   // next state
   always_comb begin
      mode_in   = mode_ff;
      phase_in  = phase_ff;
      field_in  = field_ff;
      length_in = length_ff;
      remain_in = remain_ff;
      if (mode_ff == MODE_BODY) begin
         if (remain_ff != '0) begin
            remain_in = remain_ff - 1'b1;
         end
         if (remain_le1) begin
            mode_in   = MODE_REQ;
            length_in = '0;
            phase_in  = PH_PLAIN;
         end
      end else begin
         case (phase_ff)
            PH_CRLF: begin
               if (mode_ff == MODE_HDR && is_ws) begin
                  field_in = field_byte(field_ff, data_byte);
                  phase_in = PH_PLAIN;
               end else begin
                  if (mode_ff == MODE_HDR && field_ff.in_value && !field_ff.mismatch &&
                      field_ff.name_pos == NAME_LEN) begin
                     length_in = field_ff.accum;
                  end
                  mode_in = MODE_HDR;
                  if (data_byte == CHAR_CR) begin
                     field_in = FIELD_CLEAR;
                     phase_in = PH_CRLFCR;
                  end else begin
                     field_in = field_byte(FIELD_CLEAR, data_byte);
                     phase_in = PH_PLAIN;
                  end
               end
            end
            PH_CRLFCR: begin
               if (data_byte == CHAR_LF) begin
                  field_in = FIELD_CLEAR;
                  phase_in = PH_PLAIN;
                  if (length_ff != '0) begin
                     mode_in   = MODE_BODY;
                     remain_in = length_ff;
                  end else begin
                     mode_in = MODE_REQ;
                  end
               end else begin
                  field_in = field_byte(cleared_mis, data_byte);
                  phase_in = (data_byte == CHAR_CR) ? PH_CR : PH_PLAIN;
               end
            end
            default: begin
               if (mode_ff == MODE_HDR) begin
                  field_in = field_byte(field_ff, data_byte);
               end
               if (data_byte == CHAR_CR) begin
                  phase_in = PH_CR;
               end else if (phase_ff == PH_CR && data_byte == CHAR_LF) begin
                  phase_in = PH_CRLF;
               end else begin
                  phase_in = PH_PLAIN;
               end
            end
         endcase
      end
   end

   // tag of the current byte
   always_comb begin
      tag         = '0;
      body_length = '0;
      if (mode_ff == MODE_BODY) begin
         tag.section   = SEC_BODY;
         tag.body_last = remain_le1;
      end else begin
         case (phase_ff)
            PH_CRLF: begin
               tag.section    = SEC_HDR;
               tag.line_start = !(mode_ff == MODE_HDR && is_ws) && data_byte != CHAR_CR;
            end
            PH_CRLFCR: begin
               tag.section = SEC_HDR;
               if (data_byte == CHAR_LF) begin
                  tag.header_done = 1'b1;
                  body_length     = length_ff;
               end else begin
                  tag.line_start = 1'b1;
               end
            end
            default: begin
               tag.section = (mode_ff == MODE_HDR) ? SEC_HDR : SEC_REQ;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_REQ;
         phase_ff  <= PH_PLAIN;
         field_ff  <= FIELD_CLEAR;
         length_ff <= '0;
         remain_ff <= '0;
      end else if (step) begin
         mode_ff   <= mode_in;
         phase_ff  <= phase_in;
         field_ff  <= field_in;
         length_ff <= length_in;
         remain_ff <= remain_in;
      end
   end

endmodule

// ===== sv/http_request_framer.sv =====
// ----------------------------------------------------------------------------
// http_request_framer
// Tags each byte of an HTTP/1.1 request stream by section and frames the body.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one raw request byte per transaction. rsp_ returns one
//   transaction per input byte, in order: the byte itself, its section
//   (request line, header area, body), line start and end-of-headers flags,
//   the parsed content length on the end-of-headers byte, and tlast on the
//   final body byte.
//   A byte accepted on req_ is loaded first into the input register and
//   then, with its parse result, into the result register that drives
//   rsp_tvalid. Throughput is one byte per cycle while the receiver does
//   not stall; the parser state advances as a byte moves into the result
//   register. Reset returns the parser to the request line with a zero
//   length and empties both registers. When the receiver stalls, the
//   result holds and the input register fills; req_tready drops once both
//   are occupied and rises in the cycle rsp_tready returns.
// ----------------------------------------------------------------------------
module http_request_framer
   import hrf_pkg::*;
#(
   parameter int LENGTH_BITS = 32
)
(
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // data_byte
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((8+LENGTH_BITS+7)/8)*8-1:0]  rsp_tdata,  // echo_byte, body_length
   output logic [3:0]                          rsp_tuser,  // section, line_start, header_done
   output logic                                rsp_tlast   // body_last
);

   localparam int DATA_BITS = ((8 + LENGTH_BITS + 7) / 8) * 8;

   logic                   advance;
   logic                   stage_valid;
   logic [7:0]             stage_byte;
   tag_type                tag;
   logic [LENGTH_BITS-1:0] length;

   logic                   valid_ff;
   logic [7:0]             byte_ff;
   tag_type                tag_ff;
   logic [LENGTH_BITS-1:0] length_ff;

   assign advance = !valid_ff || rsp_tready;

   hrf_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_byte    (req_tdata),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage_byte  (stage_byte)
   );

   hrf_parser #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (advance && stage_valid),
      .data_byte   (stage_byte),
      .tag         (tag),
      .body_length (length)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= stage_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && stage_valid) begin
         byte_ff   <= stage_byte;
         tag_ff    <= tag;
         length_ff <= length;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = DATA_BITS'({length_ff, byte_ff});
   assign rsp_tuser  = {tag_ff.header_done, tag_ff.line_start, tag_ff.section};
   assign rsp_tlast  = tag_ff.body_last;

endmodule

// ===== sv/hrf_checker.sv =====
// ----------------------------------------------------------------------------
// hrf_checker
// Port-level checks of the HTTP request framer result stream.
// ----------------------------------------------------------------------------
module hrf_checker
   import hrf_pkg::*;
#(
   parameter int LENGTH_BITS = 32
)
(
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [((8+LENGTH_BITS+7)/8)*8-1:0] rsp_tdata,
   input  logic [3:0]                         rsp_tuser,
   input  logic                               rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_done_is_lf: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3] |->
         rsp_tdata[7:0] == CHAR_LF && rsp_tuser[1:0] == SEC_HDR && !rsp_tuser[2])
      else $error("end of headers not on a header LF");

   a_last_in_body: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[1:0] == SEC_BODY)
      else $error("body_last outside the body");

   a_line_in_hdr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tuser[1:0] == SEC_HDR)
      else $error("line_start outside the header area");

   a_no_len_off_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[3] |-> rsp_tdata[8+LENGTH_BITS-1:8] == '0)
      else $error("length shown outside end of headers");

endmodule

bind http_request_framer hrf_checker #(
   .LENGTH_BITS (LENGTH_BITS)
) u_hrf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== test/http_request_framer_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// http_request_framer_check
// Watches both streams of the request framer and scores every tag it returns.
// Each accepted request byte is run through a local copy of the framing rules
// (sections, field folding, content-length parsing, body count). The tag that
// results is queued, and each response transaction is compared with the oldest
// queued tag field by field.
// ----------------------------------------------------------------------------
module http_request_framer_check
   import hrf_pkg::*;
#(
   parameter int LENGTH_BITS = 32
)
(
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [7:0]                          req_tdata,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [((8+LENGTH_BITS+7)/8)*8-1:0]  rsp_tdata,
   input  logic [3:0]                          rsp_tuser,
   input  logic                                rsp_tlast,
   output int                                  error_count,
   output int                                  tags_outstanding
);

   localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = {LENGTH_BITS{1'b1}};
   localparam string LENGTH_NAME = "content-length";

   typedef struct packed {
      logic [7:0]             echo;
      tag_type                tag;
      logic [LENGTH_BITS-1:0] length;
   } tag_rec_type;

   tag_rec_type pending_tags[$];
   int          rsp_index;

   // parser state
   mode_type               mode;
   phase_type              phase;
   logic [3:0]             name_pos;
   logic                   name_bad;
   logic                   in_value;
   logic                   skip_lead;
   logic                   digits_done;
   logic [LENGTH_BITS-1:0] accum;
   logic [LENGTH_BITS-1:0] length;
   logic [LENGTH_BITS-1:0] remaining;

   initial begin
      error_count = 0;
      tags_outstanding = 0;
      rsp_index = 0;
   end

   task automatic report_error(input string msg);
      if (error_count < 200)
         $display("[%0t] ERROR: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want)
         report_error($sformatf("transaction %0d %s: expected %0h, got %0h",
                                rsp_index, name, want, got));
   endtask

   function automatic void clear_field();
      name_pos = '0;
      name_bad = 1'b0;
      in_value = 1'b0;
      skip_lead = 1'b0;
      digits_done = 1'b0;
      accum = '0;
   endfunction

   function automatic void scan_field_byte(input logic [7:0] b);
      logic [7:0]             lc;
      logic [LENGTH_BITS-1:0] d;
      if (!in_value) begin
         lc = (b >= CHAR_UC_A && b <= CHAR_UC_Z) ? b + CASE_OFS : b;
         if (b == CHAR_COLON) begin
            in_value = 1'b1;
            skip_lead = 1'b1;
            digits_done = 1'b0;
            accum = '0;
         end else if (!name_bad && name_pos < NAME_LEN && lc == LENGTH_NAME[name_pos]) begin
            name_pos++;
         end else begin
            name_bad = 1'b1;
         end
      end else if (!(skip_lead && (b == CHAR_SP || b == CHAR_HT))) begin
         skip_lead = 1'b0;
         if (!digits_done && b >= CHAR_ZERO && b <= CHAR_NINE) begin
            d = b - CHAR_ZERO;
            if (accum > (LENGTH_MAX - d) / 10)
               accum = LENGTH_MAX;
            else
               accum = accum * 10 + d;
         end else begin
            digits_done = 1'b1;
         end
      end
   endfunction

   function automatic tag_rec_type frame_byte(input logic [7:0] b);
      tag_rec_type t;
      t = '0;
      t.echo = b;
      if (mode == MODE_BODY) begin
         t.tag.section = SEC_BODY;
         if (remaining != 0)
            remaining--;
         if (remaining == 0) begin
            t.tag.body_last = 1'b1;
            mode = MODE_REQ;
            length = '0;
            phase = PH_PLAIN;
         end
      end else if (phase == PH_CRLF) begin
         t.tag.section = SEC_HDR;
         if (mode == MODE_HDR && (b == CHAR_SP || b == CHAR_HT)) begin
            // folded line, same field
            scan_field_byte(b);
            phase = PH_PLAIN;
         end else begin
            if (mode == MODE_HDR && in_value && !name_bad && name_pos == NAME_LEN)
               length = accum;
            clear_field();
            mode = MODE_HDR;
            if (b == CHAR_CR) begin
               phase = PH_CRLFCR;
            end else begin
               t.tag.line_start = 1'b1;
               scan_field_byte(b);
               phase = PH_PLAIN;
            end
         end
      end else if (phase == PH_CRLFCR) begin
         t.tag.section = SEC_HDR;
         if (b == CHAR_LF) begin
            t.tag.header_done = 1'b1;
            t.length = length;
            clear_field();
            phase = PH_PLAIN;
            if (length != 0) begin
               mode = MODE_BODY;
               remaining = length;
            end else begin
               mode = MODE_REQ;
            end
         end else begin
            // stray CR opens a line whose name can never match
            clear_field();
            name_bad = 1'b1;
            t.tag.line_start = 1'b1;
            scan_field_byte(b);
            phase = (b == CHAR_CR) ? PH_CR : PH_PLAIN;
         end
      end else begin
         t.tag.section = (mode == MODE_HDR) ? SEC_HDR : SEC_REQ;
         if (mode == MODE_HDR)
            scan_field_byte(b);
         if (b == CHAR_CR)
            phase = PH_CR;
         else if (phase == PH_CR && b == CHAR_LF)
            phase = PH_CRLF;
         else
            phase = PH_PLAIN;
      end
      return t;
   endfunction

   always @(posedge clock) begin : monitor
      tag_rec_type want;
      if (reset) begin
         mode = MODE_REQ;
         phase = PH_PLAIN;
         clear_field();
         length = '0;
         remaining = '0;
         pending_tags.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_tags.size() == 0) begin
               report_error($sformatf("transaction %0d with no tag pending, byte %02h",
                                      rsp_index, rsp_tdata[7:0]));
            end else begin
               want = pending_tags.pop_front();
               check_field("echo_byte", want.echo, rsp_tdata[7:0]);
               check_field("section", want.tag.section, rsp_tuser[1:0]);
               check_field("line_start", want.tag.line_start, rsp_tuser[2]);
               check_field("header_done", want.tag.header_done, rsp_tuser[3]);
               check_field("body_last", want.tag.body_last, rsp_tlast);
               check_field("body_length", want.length, rsp_tdata[8 +: LENGTH_BITS]);
            end
            rsp_index++;
         end
         if (req_tvalid && req_tready)
            pending_tags.push_back(frame_byte(req_tdata));
      end
      tags_outstanding = pending_tags.size();
   end

endmodule

// ===== test/tb_http_request_framer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_http_request_framer
// Stimulus and verdict for the HTTP request framer.
// A short directed stream opens the run, followed by randomly built requests:
// random request lines, content-length fields in mixed case with leading
// blanks, folding, overflow, empty and junk values, near-miss names, lines
// without a colon or opening with a stray CR, and bodies of random bytes,
// with some raw noise between requests. Both sides idle at random; the
// receiver once stalls long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_http_request_framer;
   import hrf_pkg::*;

   localparam int LENGTH_BITS = 32;
   localparam int RSP_W = ((8 + LENGTH_BITS + 7) / 8) * 8;
   localparam int BYTE_TARGET = 600;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [7:0]       req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;   // echo_byte, body_length
   logic [3:0]       rsp_tuser;   // section, line_start, header_done
   logic             rsp_tlast;   // body_last

   int         error_count;
   int         tags_outstanding;
   bit         tx_quiet;
   bit         rx_hold;
   logic [7:0] stream_q[$];

   always #5 clock = ~clock;

   http_request_framer #(.LENGTH_BITS(LENGTH_BITS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   http_request_framer_check #(.LENGTH_BITS(LENGTH_BITS)) tag_check (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .rsp_tlast        (rsp_tlast),
      .error_count      (error_count),
      .tags_outstanding (tags_outstanding)
   );

   // ---- stream building ----

   task automatic add_text(input string s);
      foreach (s[i])
         stream_q.push_back(s[i]);
   endtask

   task automatic add_text_rand(input int n);
      logic [7:0] c;
      repeat (n) begin
         do
            c = 8'($urandom_range(33, 126));
         while (c == CHAR_COLON);
         stream_q.push_back(c);
      end
   endtask

   task automatic add_eol();
      stream_q.push_back(CHAR_CR);
      stream_q.push_back(CHAR_LF);
   endtask

   task automatic add_blank();
      stream_q.push_back($urandom_range(0, 1) ? CHAR_SP : CHAR_HT);
   endtask

   task automatic add_lead();
      repeat ($urandom_range(0, 3))
         add_blank();
   endtask

   task automatic add_length_name();
      string      s;
      logic [7:0] c;
      s = "content-length";
      foreach (s[i]) begin
         c = s[i];
         if (c >= "a" && c <= "z" && $urandom_range(0, 1))
            c -= CASE_OFS;
         stream_q.push_back(c);
      end
      stream_q.push_back(CHAR_COLON);
   endtask

   task automatic build_request();
      int v;
      int body_len;
      bit big_last;
      body_len = 0;
      big_last = 0;
      add_text_rand($urandom_range(1, 8));
      add_eol();
      repeat ($urandom_range(0, 4)) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               add_length_name();
               add_lead();
               v = $urandom_range(0, 20);
               add_text($sformatf("%0d", v));
               if ($urandom_range(0, 3) == 0)
                  add_text("x7");
               body_len = v;
               big_last = 0;
            end
            3: begin
               // saturating value, always overridden further down
               add_length_name();
               add_lead();
               case ($urandom_range(0, 2))
                  0: add_text("4294967295");
                  1: add_text("4294967296");
                  default: begin
                     add_text("9");
                     repeat ($urandom_range(10, 12))
                        stream_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
                  end
               endcase
               big_last = 1;
            end
            4: begin
               add_length_name();
               add_lead();
               if ($urandom_range(0, 1))
                  add_text("n5");
               body_len = 0;
               big_last = 0;
            end
            5: begin
               // the CR of the fold ends the digits, so the value is empty
               add_length_name();
               add_eol();
               add_blank();
               v = $urandom_range(0, 20);
               add_text($sformatf("%0d", v));
               body_len = 0;
               big_last = 0;
            end
            6: begin
               case ($urandom_range(0, 3))
                  0: add_text("content-lengthx");
                  1: add_text("content-lengt");
                  2: add_text("content-length ");
                  default: add_text("xcontent-length");
               endcase
               add_text(":12");
            end
            7: begin
               add_text_rand($urandom_range(1, 6));
               stream_q.push_back(CHAR_COLON);
               add_lead();
               add_text_rand($urandom_range(0, 6));
               if ($urandom_range(0, 3) == 0) begin
                  stream_q.push_back(CHAR_CR);
                  add_text_rand(1);
               end
               if ($urandom_range(0, 2) == 0) begin
                  add_eol();
                  add_blank();
                  add_text_rand($urandom_range(1, 5));
               end
            end
            8: add_text_rand($urandom_range(1, 10));
            default: begin
               stream_q.push_back(CHAR_CR);
               if ($urandom_range(0, 2) == 0)
                  stream_q.push_back(CHAR_CR);
               add_text("content-length:3");
            end
         endcase
         add_eol();
      end
      if (big_last) begin
         add_length_name();
         v = $urandom_range(0, 12);
         add_text($sformatf("%0d", v));
         add_eol();
         body_len = v;
      end
      add_eol();
      repeat (body_len)
         stream_q.push_back(8'($urandom_range(0, 255)));
   endtask

   // raw bytes without CR keep the parser on the request line
   task automatic add_noise();
      logic [7:0] c;
      repeat ($urandom_range(1, 16)) begin
         c = 8'($urandom_range(0, 255));
         if (c == CHAR_CR)
            c = CHAR_LF;
         stream_q.push_back(c);
      end
   endtask

   // ---- driving ----

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do
         @(posedge clock);
      while (!req_tready);
   endtask

   task automatic flush_stream();
      while (stream_q.size() != 0)
         send_byte(stream_q.pop_front());
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (tags_outstanding != 0);
      @(posedge clock);
   endtask

   initial begin : receiver
      int stall;
      int quiet_run;
      rsp_tready = 1'b0;
      quiet_run = 0;
      @(posedge clock);
      forever begin
         if (rx_hold) begin
            stall = 120;
            rx_hold = 0;
         end else if (quiet_run > 0) begin
            stall = 0;
            quiet_run--;
         end else begin
            stall = $urandom_range(0, 19);
            if ($urandom_range(0, 7) == 0)
               quiet_run = $urandom_range(10, 40);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do
            @(posedge clock);
         while (!(rsp_tvalid && rsp_tready));
      end
   end

   initial begin : stimulus
      int sent;
      int req_count;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      tx_quiet = 0;
      rx_hold = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: byte extremes, mixed-case name with SP/HT lead, one-byte body,
      // then an empty request ending the headers at once
      stream_q.push_back(8'hFF);
      stream_q.push_back(8'h00);
      add_eol();
      add_text("coNTENT-length:");
      stream_q.push_back(CHAR_SP);
      stream_q.push_back(CHAR_HT);
      add_text("1");
      add_eol();
      add_eol();
      stream_q.push_back(8'hA5);
      add_eol();
      add_eol();
      flush_stream();

      sent = 0;
      req_count = 0;
      while (sent < BYTE_TARGET) begin
         tx_quiet = ($urandom_range(0, 3) == 0);
         if (req_count == 2) begin
            tx_quiet = 1;
            rx_hold = 1;
         end
         build_request();
         if ($urandom_range(0, 5) == 0)
            add_noise();
         sent += stream_q.size();
         flush_stream();
         if (req_count == 2 || $urandom_range(0, 7) == 0) begin
            req_tvalid <= 1'b0;
            wait_drained();
         end
         req_count++;
      end

      req_tvalid <= 1'b0;
      wait_drained();
      repeat (10) @(posedge clock);
      if (error_count == 0 && tags_outstanding == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/hrf_pkg.sv
sv/hrf_in_stage.sv
sv/hrf_parser.sv
sv/http_request_framer.sv
sv/hrf_checker.sv
test/http_request_framer_check.sv
test/tb_http_request_framer.sv
